FILE: src/box_face_grid_tessellator_assert.svh
// Assertion helpers for the tessellator checker.
`ifndef BOX_FACE_GRID_TESSELLATOR_ASSERT_SVH
`define BOX_FACE_GRID_TESSELLATOR_ASSERT_SVH

// Same-cycle implication, switched off while reset is low.
`define BFGT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is low.
`define BFGT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bfgt_pkg.sv
package bfgt_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned EXT_W      = COORD_W + 1;
  localparam int unsigned CELL_W     = 8;
  localparam int unsigned GRID_W     = CELL_W + 1;
  // grid position <= 2^CELL_W, so |g * extent| < 2^(COORD_W + CELL_W)
  localparam int unsigned NUM_W      = EXT_W + CELL_W;
  localparam int unsigned DIV_W      = NUM_W - 1;
  localparam int unsigned DIV_STEPS  = 8;
  localparam int unsigned DIV_STAGES = DIV_W / DIV_STEPS;
  localparam int unsigned N_LANES    = 4;
  // two front stages, the divider, one point stage
  localparam int unsigned PIPE_DEPTH = DIV_STAGES + 3;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam int unsigned GRID_MAX_W = 16;
  localparam logic [GRID_MAX_W-1:0] GRID_MAX = 16'd255;

  localparam logic [2:0] FACE_NEG_X = 3'd0;
  localparam logic [2:0] FACE_POS_X = 3'd1;
  localparam logic [2:0] FACE_NEG_Y = 3'd2;
  localparam logic [2:0] FACE_POS_Y = 3'd3;
  localparam logic [2:0] FACE_NEG_Z = 3'd4;
  localparam logic [2:0] FACE_POS_Z = 3'd5;

  localparam logic [2:0] SLOT_FIRST    = 3'd0;
  localparam logic [2:0] SLOT_NEAR     = 3'd1;
  localparam logic [2:0] SLOT_FAR      = 3'd2;
  localparam logic [2:0] SLOT_FAR_DUP  = 3'd3;
  localparam logic [2:0] SLOT_NEAR_DUP = 3'd4;
  localparam logic [2:0] SLOT_LAST     = 3'd5;

  typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_e;
  typedef enum logic [1:0] {LANE_U0, LANE_U1, LANE_V0, LANE_V1} lane_e;
  typedef enum logic [1:0] {PT_A, PT_B, PT_C, PT_D} point_e;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X, REG_MIN_Y, REG_MIN_Z, REG_MAX_X, REG_MAX_Y, REG_MAX_Z, REG_CCW
  } reg_e;

  typedef logic [2:0][COORD_W-1:0] vec3_t;

  typedef struct packed {
    vec3_t box_min;
    vec3_t box_max;
    logic  ccw_front;
  } cfg_t;

  typedef struct packed {
    logic [2:0] face;
    logic       flip;
    logic       zero_u;
    logic       zero_v;
  } item_ctl_t;

  // one lane of the restoring divider: dq holds the unused dividend bits
  // on top and the quotient bits shifted in from below
  typedef struct packed {
    logic              neg;
    logic [CELL_W-1:0] den;
    logic [CELL_W-1:0] rem;
    logic [DIV_W-1:0]  dq;
  } div_lane_t;

  typedef div_lane_t [N_LANES-1:0] lane_vec_t;

  function automatic axis_e u_axis(input logic [2:0] face);
    axis_e ax;
    unique case (face)
      FACE_NEG_Y, FACE_POS_Y, FACE_NEG_Z, FACE_POS_Z: ax = AXIS_X;
      default:                                        ax = AXIS_Y;
    endcase
    return ax;
  endfunction

  function automatic axis_e v_axis(input logic [2:0] face);
    axis_e ax;
    unique case (face)
      FACE_NEG_Z, FACE_POS_Z: ax = AXIS_Y;
      default:                ax = AXIS_Z;
    endcase
    return ax;
  endfunction

  function automatic axis_e fixed_axis(input logic [2:0] face);
    axis_e ax;
    unique case (face)
      FACE_NEG_Y, FACE_POS_Y: ax = AXIS_Y;
      FACE_NEG_Z, FACE_POS_Z: ax = AXIS_Z;
      default:                ax = AXIS_X;
    endcase
    return ax;
  endfunction

  function automatic logic fixed_is_max(input logic [2:0] face);
    return (face == FACE_POS_X) || (face == FACE_POS_Y) || (face == FACE_POS_Z);
  endfunction

  function automatic logic base_flip(input logic [2:0] face);
    return (face == FACE_POS_X) || (face == FACE_NEG_Y) || (face == FACE_POS_Z);
  endfunction

endpackage

FILE: src/bfgt_cfg_regs.sv
module bfgt_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [bfgt_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bfgt_pkg::COORD_W-1:0]      cfg_data_i,
  output bfgt_pkg::cfg_t                    cfg_o
);

  bfgt_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bfgt_pkg::REG_MIN_X: cfg_q.box_min[bfgt_pkg::AXIS_X] <= cfg_data_i;
        bfgt_pkg::REG_MIN_Y: cfg_q.box_min[bfgt_pkg::AXIS_Y] <= cfg_data_i;
        bfgt_pkg::REG_MIN_Z: cfg_q.box_min[bfgt_pkg::AXIS_Z] <= cfg_data_i;
        bfgt_pkg::REG_MAX_X: cfg_q.box_max[bfgt_pkg::AXIS_X] <= cfg_data_i;
        bfgt_pkg::REG_MAX_Y: cfg_q.box_max[bfgt_pkg::AXIS_Y] <= cfg_data_i;
        bfgt_pkg::REG_MAX_Z: cfg_q.box_max[bfgt_pkg::AXIS_Z] <= cfg_data_i;
        bfgt_pkg::REG_CCW:   cfg_q.ccw_front <= cfg_data_i[0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/bfgt_front.sv
module bfgt_front (
  input  logic                         clk_i,
  input  logic                         adv_i,
  input  bfgt_pkg::cfg_t               cfg_i,
  input  logic [2:0]                   face_i,
  input  logic [bfgt_pkg::CELL_W-1:0]  cell_u_i,
  input  logic [bfgt_pkg::CELL_W-1:0]  cell_v_i,
  input  logic [bfgt_pkg::CELL_W-1:0]  count_u_i,
  input  logic [bfgt_pkg::CELL_W-1:0]  count_v_i,
  output bfgt_pkg::item_ctl_t          ctl_o,
  output bfgt_pkg::lane_vec_t          lanes_o
);

  localparam int unsigned CW = bfgt_pkg::CELL_W;
  localparam int unsigned OW = bfgt_pkg::COORD_W;
  localparam int unsigned EW = bfgt_pkg::EXT_W;
  localparam int unsigned GW = bfgt_pkg::GRID_W;
  localparam int unsigned NW = bfgt_pkg::NUM_W;
  localparam int unsigned DW = bfgt_pkg::DIV_W;
  localparam int unsigned NL = bfgt_pkg::N_LANES;
  localparam int unsigned MW = bfgt_pkg::GRID_MAX_W;

  function automatic logic [CW-1:0] sat_count(input logic [CW-1:0] n);
    logic [CW-1:0] r;
    r = n;
    if (MW'(n) > bfgt_pkg::GRID_MAX) r = bfgt_pkg::GRID_MAX[CW-1:0];
    return r;
  endfunction

  // stage 1: axis select, extents, grid positions, counts
  bfgt_pkg::item_ctl_t        ctl1_d, ctl1_q;
  logic signed [EW-1:0]       ext_u_d, ext_u_q, ext_v_d, ext_v_q;
  logic [NL-1:0][GW-1:0]      g_d, g_q;
  logic [CW-1:0]              den_u_d, den_u_q, den_v_d, den_v_q;
  bfgt_pkg::axis_e            ax_u, ax_v;
  logic [OW-1:0]              lo_u, hi_u, lo_v, hi_v;

  always_comb begin
    ax_u = bfgt_pkg::u_axis(face_i);
    ax_v = bfgt_pkg::v_axis(face_i);
    lo_u = cfg_i.box_min[ax_u];
    hi_u = cfg_i.box_max[ax_u];
    lo_v = cfg_i.box_min[ax_v];
    hi_v = cfg_i.box_max[ax_v];
    ext_u_d = $signed({hi_u[OW-1], hi_u}) - $signed({lo_u[OW-1], lo_u});
    ext_v_d = $signed({hi_v[OW-1], hi_v}) - $signed({lo_v[OW-1], lo_v});
    g_d[bfgt_pkg::LANE_U0] = {1'b0, cell_u_i};
    g_d[bfgt_pkg::LANE_U1] = {1'b0, cell_u_i} + GW'(1);
    g_d[bfgt_pkg::LANE_V0] = {1'b0, cell_v_i};
    g_d[bfgt_pkg::LANE_V1] = {1'b0, cell_v_i} + GW'(1);
    den_u_d = sat_count(count_u_i);
    den_v_d = sat_count(count_v_i);
    ctl1_d.face   = face_i;
    ctl1_d.flip   = bfgt_pkg::base_flip(face_i) ^ cfg_i.ccw_front;
    ctl1_d.zero_u = (count_u_i == '0);
    ctl1_d.zero_v = (count_v_i == '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctl1_q  <= ctl1_d;
      ext_u_q <= ext_u_d;
      ext_v_q <= ext_v_d;
      g_q     <= g_d;
      den_u_q <= den_u_d;
      den_v_q <= den_v_d;
    end
  end

  // stage 2: g * extent per lane
  bfgt_pkg::item_ctl_t        ctl2_q;
  logic [NL-1:0][NW-1:0]      num_d, num_q;
  logic [NL-1:0][CW-1:0]      den_d, den_q;

  always_comb begin
    logic signed [EW+GW-1:0] prod;
    logic signed [EW-1:0]    ext_sel;
    for (int k = 0; k < NL; k++) begin
      if (k == bfgt_pkg::LANE_U0 || k == bfgt_pkg::LANE_U1) begin
        ext_sel  = ext_u_q;
        den_d[k] = den_u_q;
      end else begin
        ext_sel  = ext_v_q;
        den_d[k] = den_v_q;
      end
      prod     = ext_sel * $signed({1'b0, g_q[k]});
      num_d[k] = prod[NW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctl2_q <= ctl1_q;
      num_q  <= num_d;
      den_q  <= den_d;
    end
  end

  // floor(n/d) for n < 0 is ~(~n / d), so the divider only sees magnitudes
  always_comb begin
    for (int k = 0; k < NL; k++) begin
      lanes_o[k].neg = num_q[k][NW-1];
      lanes_o[k].den = den_q[k];
      lanes_o[k].rem = '0;
      lanes_o[k].dq  = num_q[k][NW-1] ? ~num_q[k][DW-1:0] : num_q[k][DW-1:0];
    end
  end

  assign ctl_o = ctl2_q;

endmodule

FILE: src/bfgt_div_stage.sv
module bfgt_div_stage (
  input  logic                 clk_i,
  input  logic                 adv_i,
  input  bfgt_pkg::lane_vec_t  lanes_i,
  input  bfgt_pkg::item_ctl_t  ctl_i,
  output bfgt_pkg::lane_vec_t  lanes_o,
  output bfgt_pkg::item_ctl_t  ctl_o
);

  localparam int unsigned CW = bfgt_pkg::CELL_W;
  localparam int unsigned DW = bfgt_pkg::DIV_W;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  function automatic bfgt_pkg::div_lane_t div_step(input bfgt_pkg::div_lane_t l);
    bfgt_pkg::div_lane_t r;
    logic [CW:0]         trial;
    trial = {l.rem, l.dq[DW-1]};
    r     = l;
    if (trial >= {1'b0, l.den}) begin
      r.rem = CW'(trial - {1'b0, l.den});
      r.dq  = {l.dq[DW-2:0], 1'b1};
    end else begin
      r.rem = trial[CW-1:0];
      r.dq  = {l.dq[DW-2:0], 1'b0};
    end
    return r;
  endfunction

  bfgt_pkg::lane_vec_t lanes_d, lanes_q;
  bfgt_pkg::item_ctl_t ctl_q;

  always_comb begin
    lanes_d = lanes_i;
    for (int k = 0; k < bfgt_pkg::N_LANES; k++) begin
      for (int s = 0; s < bfgt_pkg::DIV_STEPS; s++) begin
        lanes_d[k] = div_step(lanes_d[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lanes_q <= lanes_d;
      ctl_q   <= ctl_i;
    end
  end

  assign lanes_o = lanes_q;
  assign ctl_o   = ctl_q;

endmodule

FILE: src/bfgt_emit.sv
module bfgt_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          vld_i,
  input  bfgt_pkg::cfg_t                cfg_i,
  input  bfgt_pkg::lane_vec_t           lanes_i,
  input  bfgt_pkg::item_ctl_t           ctl_i,
  output logic                          done_o,
  output logic                          vertex_valid_o,
  output logic signed [bfgt_pkg::COORD_W-1:0] vertex_x_o,
  output logic signed [bfgt_pkg::COORD_W-1:0] vertex_y_o,
  output logic signed [bfgt_pkg::COORD_W-1:0] vertex_z_o,
  output logic [2:0]                    corner_slot_o,
  output logic                          last_vertex_o
);

  localparam int unsigned OW = bfgt_pkg::COORD_W;

  function automatic logic [OW-1:0] grid_coord(input bfgt_pkg::div_lane_t l,
                                               input logic [OW-1:0] lo,
                                               input logic zero);
    logic [OW-1:0] q;
    logic [OW-1:0] off;
    q   = l.dq[OW-1:0];
    off = l.neg ? ~q : q;
    return lo + (zero ? '0 : off);
  endfunction

  function automatic bfgt_pkg::vec3_t place(input logic [2:0] face,
                                            input logic [OW-1:0] fix_val,
                                            input logic [OW-1:0] pu,
                                            input logic [OW-1:0] pv);
    bfgt_pkg::vec3_t p;
    p = '0;
    p[bfgt_pkg::fixed_axis(face)] = fix_val;
    p[bfgt_pkg::u_axis(face)]     = pu;
    p[bfgt_pkg::v_axis(face)]     = pv;
    return p;
  endfunction

  // A,B,C,C,B,D, or A,C,B,B,C,D when flipped
  function automatic bfgt_pkg::point_e slot_point(input logic [2:0] slot, input logic flip);
    bfgt_pkg::point_e pt;
    unique case (slot)
      bfgt_pkg::SLOT_FIRST:                           pt = bfgt_pkg::PT_A;
      bfgt_pkg::SLOT_NEAR, bfgt_pkg::SLOT_NEAR_DUP:   pt = flip ? bfgt_pkg::PT_C
                                                                : bfgt_pkg::PT_B;
      bfgt_pkg::SLOT_FAR, bfgt_pkg::SLOT_FAR_DUP:     pt = flip ? bfgt_pkg::PT_B
                                                                : bfgt_pkg::PT_C;
      bfgt_pkg::SLOT_LAST:                            pt = bfgt_pkg::PT_D;
      default:                                        pt = bfgt_pkg::PT_A;
    endcase
    return pt;
  endfunction

  // final stage: offsets onto the low corner, points assembled
  bfgt_pkg::vec3_t [3:0] pts_d, pts_q;
  logic                  flip_q;
  bfgt_pkg::axis_e       ax_u, ax_v, ax_f;
  logic [OW-1:0]         u0, u1, v0, v1, fix_val;

  always_comb begin
    ax_u = bfgt_pkg::u_axis(ctl_i.face);
    ax_v = bfgt_pkg::v_axis(ctl_i.face);
    ax_f = bfgt_pkg::fixed_axis(ctl_i.face);
    u0 = grid_coord(lanes_i[bfgt_pkg::LANE_U0], cfg_i.box_min[ax_u], ctl_i.zero_u);
    u1 = grid_coord(lanes_i[bfgt_pkg::LANE_U1], cfg_i.box_min[ax_u], ctl_i.zero_u);
    v0 = grid_coord(lanes_i[bfgt_pkg::LANE_V0], cfg_i.box_min[ax_v], ctl_i.zero_v);
    v1 = grid_coord(lanes_i[bfgt_pkg::LANE_V1], cfg_i.box_min[ax_v], ctl_i.zero_v);
    fix_val = bfgt_pkg::fixed_is_max(ctl_i.face) ? cfg_i.box_max[ax_f]
                                                 : cfg_i.box_min[ax_f];
    pts_d[bfgt_pkg::PT_A] = place(ctl_i.face, fix_val, u0, v0);
    pts_d[bfgt_pkg::PT_B] = place(ctl_i.face, fix_val, u0, v1);
    pts_d[bfgt_pkg::PT_C] = place(ctl_i.face, fix_val, u1, v0);
    pts_d[bfgt_pkg::PT_D] = place(ctl_i.face, fix_val, u1, v1);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pts_q  <= pts_d;
      flip_q <= ctl_i.flip;
    end
  end

  // vertex sequencer, one slot per cycle while the final stage is full
  logic [2:0] slot_d, slot_q;
  logic       out_vld_q;

  always_comb begin
    slot_d = slot_q;
    if (vld_i) begin
      slot_d = (slot_q == bfgt_pkg::SLOT_LAST) ? bfgt_pkg::SLOT_FIRST : slot_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= bfgt_pkg::SLOT_FIRST;
      out_vld_q <= 1'b0;
    end else begin
      slot_q    <= slot_d;
      out_vld_q <= vld_i;
    end
  end

  bfgt_pkg::vec3_t vtx_q;
  logic [2:0]      corner_q;
  logic            last_q;

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      vtx_q    <= pts_q[slot_point(slot_q, flip_q)];
      corner_q <= slot_q;
      last_q   <= (slot_q == bfgt_pkg::SLOT_LAST);
    end
  end

  assign done_o         = vld_i && (slot_q == bfgt_pkg::SLOT_LAST);
  assign vertex_valid_o = out_vld_q;
  assign vertex_x_o     = $signed(vtx_q[bfgt_pkg::AXIS_X]);
  assign vertex_y_o     = $signed(vtx_q[bfgt_pkg::AXIS_Y]);
  assign vertex_z_o     = $signed(vtx_q[bfgt_pkg::AXIS_Z]);
  assign corner_slot_o  = corner_q;
  assign last_vertex_o  = last_q;

endmodule

FILE: src/box_face_grid_tessellator.sv
// Box face grid tessellator: one grid cell of one box face in, six vertices out.
// Request channel: face_i, cell_u_i, cell_v_i, count_u_i and count_v_i are taken
// at a rising edge with start high and busy low. Results: one vertex per cycle
// on vertex_x/y/z_o, corner_slot_o and last_vertex_o, marked by vertex_valid_o
// for exactly one cycle; last_vertex_o flags the sixth vertex of the cell.
// Config: cfg_index_i / cfg_data_i written when cfg_valid_i and cfg_ready_o are
// both high (always ready). Index 0..5 box min x,y,z and max x,y,z, 6 ccw_front.
// A request passes the PIPE_DEPTH stages and then the vertex output register;
// its six vertices leave back to back, and the request rate is set by the
// single vertex output.
// Pipeline: operand select, multiply, 5 divider stages of 8 quotient bits,
// point assembly. The whole pipeline holds while the final stage still has
// slots to send; busy is high exactly then. Reset clears the config
// registers to 0 and all valid bits; no vertex is sent until a request
// arrives. The receiver cannot stall.
module box_face_grid_tessellator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          face_i,
  input  logic [bfgt_pkg::CELL_W-1:0]         cell_u_i,
  input  logic [bfgt_pkg::CELL_W-1:0]         cell_v_i,
  input  logic [bfgt_pkg::CELL_W-1:0]         count_u_i,
  input  logic [bfgt_pkg::CELL_W-1:0]         count_v_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bfgt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bfgt_pkg::COORD_W-1:0]        cfg_data_i,
  output logic                                vertex_valid_o,
  output logic signed [bfgt_pkg::COORD_W-1:0] vertex_x_o,
  output logic signed [bfgt_pkg::COORD_W-1:0] vertex_y_o,
  output logic signed [bfgt_pkg::COORD_W-1:0] vertex_z_o,
  output logic [2:0]                          corner_slot_o,
  output logic                                last_vertex_o
);

  localparam int unsigned PD = bfgt_pkg::PIPE_DEPTH;
  localparam int unsigned DS = bfgt_pkg::DIV_STAGES;

  bfgt_pkg::cfg_t cfg;

  // config writes are never held off
  assign cfg_ready_o = 1'b1;

  bfgt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Global advance: everything moves unless the final stage is still sending.
  logic          adv;
  logic          cell_done;
  logic          accept;
  logic [PD-1:0] vld_d, vld_q;

  assign adv    = !vld_q[PD-1] || cell_done;
  assign busy   = !adv;
  assign accept = start && !busy;

  always_comb begin
    vld_d = vld_q;
    if (adv) begin
      vld_d = {vld_q[PD-2:0], accept};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  bfgt_pkg::item_ctl_t [DS:0] ctl_chain;
  bfgt_pkg::lane_vec_t [DS:0] lane_chain;

  bfgt_front u_front (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .cfg_i     (cfg),
    .face_i    (face_i),
    .cell_u_i  (cell_u_i),
    .cell_v_i  (cell_v_i),
    .count_u_i (count_u_i),
    .count_v_i (count_v_i),
    .ctl_o     (ctl_chain[0]),
    .lanes_o   (lane_chain[0])
  );

  // four lanes share each stage: u, u+1, v, v+1
  for (genvar s = 0; s < DS; s++) begin : g_div
    bfgt_div_stage u_div (
      .clk_i   (clk_i),
      .adv_i   (adv),
      .lanes_i (lane_chain[s]),
      .ctl_i   (ctl_chain[s]),
      .lanes_o (lane_chain[s+1]),
      .ctl_o   (ctl_chain[s+1])
    );
  end

  bfgt_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .vld_i          (vld_q[PD-1]),
    .cfg_i          (cfg),
    .lanes_i        (lane_chain[DS]),
    .ctl_i          (ctl_chain[DS]),
    .done_o         (cell_done),
    .vertex_valid_o (vertex_valid_o),
    .vertex_x_o     (vertex_x_o),
    .vertex_y_o     (vertex_y_o),
    .vertex_z_o     (vertex_z_o),
    .corner_slot_o  (corner_slot_o),
    .last_vertex_o  (last_vertex_o)
  );

endmodule

FILE: src/bfgt_checker.sv
`include "box_face_grid_tessellator_assert.svh"

module bfgt_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                busy,
  input logic                                vertex_valid_o,
  input logic signed [bfgt_pkg::COORD_W-1:0] vertex_x_o,
  input logic signed [bfgt_pkg::COORD_W-1:0] vertex_y_o,
  input logic signed [bfgt_pkg::COORD_W-1:0] vertex_z_o,
  input logic [2:0]                          corner_slot_o
);

  // the six vertices of a cell leave in consecutive cycles
  `BFGT_ASSERT_NEXT(a_slots_back_to_back, clk_i, rst_ni, vertex_valid_o && (corner_slot_o != bfgt_pkg::SLOT_LAST), vertex_valid_o && (corner_slot_o == $past(corner_slot_o) + 3'd1), "vertex slots not back to back")

  // the far corner, shared by both triangles, comes out twice in a row
  `BFGT_ASSERT_NOW(a_shared_corner, clk_i, rst_ni, vertex_valid_o && (corner_slot_o == bfgt_pkg::SLOT_FAR_DUP), (vertex_x_o == $past(vertex_x_o)) && (vertex_y_o == $past(vertex_y_o)) && (vertex_z_o == $past(vertex_z_o)), "shared corner differs")

  // busy only while a cell is being sent out
  `BFGT_ASSERT_NEXT(a_busy_sends, clk_i, rst_ni, busy, vertex_valid_o, "busy without a vertex following")

endmodule

bind box_face_grid_tessellator bfgt_checker u_bfgt_checker (.*);

FILE: bench/tb_box_face_grid_tessellator.sv
`timescale 1ns / 1ps

// Bench for the box face tessellator. Requests (one grid cell of one face) are
// queued by the stimulus process and fed by a clocked driver; a clocked monitor
// predicts the six vertices of every accepted request and checks them in order.
module tb_box_face_grid_tessellator;

  localparam int unsigned IDLE_LIMIT  = 2000;  // cycles with no traffic at all
  localparam int unsigned SETTLE_CYCS = bfgt_pkg::PIPE_DEPTH + 8;

  typedef struct {
    logic [2:0] face;
    logic [7:0] cu;
    logic [7:0] cv;
    logic [7:0] nu;
    logic [7:0] nv;
    bit         drain_first;  // hold this request until all vertices are back
  } cell_req_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [2:0]  slot;
    logic        last;
  } vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  face_i = '0;
  logic [7:0]  cell_u_i = '0;
  logic [7:0]  cell_v_i = '0;
  logic [7:0]  count_u_i = '0;
  logic [7:0]  count_v_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [bfgt_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        vertex_valid_o;
  logic signed [31:0] vertex_x_o;
  logic signed [31:0] vertex_y_o;
  logic signed [31:0] vertex_z_o;
  logic [2:0]  corner_slot_o;
  logic        last_vertex_o;

  box_face_grid_tessellator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .face_i         (face_i),
    .cell_u_i       (cell_u_i),
    .cell_v_i       (cell_v_i),
    .count_u_i      (count_u_i),
    .count_v_i      (count_v_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .vertex_valid_o (vertex_valid_o),
    .vertex_x_o     (vertex_x_o),
    .vertex_y_o     (vertex_y_o),
    .vertex_z_o     (vertex_z_o),
    .corner_slot_o  (corner_slot_o),
    .last_vertex_o  (last_vertex_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the box registers; index 0/1/2 is x/y/z.
  logic [31:0] box_lo [3] = '{default: '0};
  logic [31:0] box_hi [3] = '{default: '0};
  logic        ccw_front = 1'b0;

  cell_req_t pending_cells [$];
  vertex_t   vertices_due  [$];

  int unsigned n_issued = 0;   // requests put on the ports
  int unsigned n_taken = 0;    // requests accepted by the block
  int unsigned n_checked = 0;
  int unsigned n_settings = 0;
  int unsigned n_errors = 0;
  int unsigned gap_cap = 10;   // 0 gives back-to-back requests
  int unsigned gap_left = 0;
  int unsigned idle_cycs = 0;

  // lo + floor(g * (hi - lo) / n), wrapped to 32 bits; n = 0 pins to lo
  function automatic logic [31:0] grid_coord(logic [31:0] lo, logic [31:0] hi,
                                             int unsigned g, logic [7:0] n);
    longint lo_s, span, num, q, den;
    int unsigned cells;
    lo_s  = longint'(signed'(lo));
    span  = longint'(signed'(hi)) - lo_s;
    cells = 32'(n);
    if (cells > 32'(bfgt_pkg::GRID_MAX)) cells = 32'(bfgt_pkg::GRID_MAX);
    if (cells == 0) return lo;
    den = longint'(cells);
    num = longint'(g) * span;
    q   = num / den;
    // division truncates towards zero; pull negatives down to the floor
    if ((num % den) != 0 && num < 0) q = q - 1;
    return lo + q[31:0];
  endfunction

  function automatic bfgt_pkg::vec3_t face_corner(logic [2:0] face, int unsigned gu,
                                                  int unsigned gv,
                                                  logic [7:0] nu, logic [7:0] nv);
    bfgt_pkg::vec3_t p;
    case (face)
      bfgt_pkg::FACE_NEG_Y, bfgt_pkg::FACE_POS_Y: begin
        p[0] = grid_coord(box_lo[0], box_hi[0], gu, nu);
        p[1] = (face == bfgt_pkg::FACE_POS_Y) ? box_hi[1] : box_lo[1];
        p[2] = grid_coord(box_lo[2], box_hi[2], gv, nv);
      end
      bfgt_pkg::FACE_NEG_Z, bfgt_pkg::FACE_POS_Z: begin
        p[0] = grid_coord(box_lo[0], box_hi[0], gu, nu);
        p[1] = grid_coord(box_lo[1], box_hi[1], gv, nv);
        p[2] = (face == bfgt_pkg::FACE_POS_Z) ? box_hi[2] : box_lo[2];
      end
      default: begin
        // -X, +X and the two unused codes, which fall back to -X geometry
        p[0] = (face == bfgt_pkg::FACE_POS_X) ? box_hi[0] : box_lo[0];
        p[1] = grid_coord(box_lo[1], box_hi[1], gu, nu);
        p[2] = grid_coord(box_lo[2], box_hi[2], gv, nv);
      end
    endcase
    return p;
  endfunction

  // Queue the six vertices a request should produce: A,B,C,C,B,D or, with the
  // winding flipped, A,C,B,B,C,D.
  function automatic void queue_cell_vertices(logic [2:0] face, logic [7:0] cu,
                                              logic [7:0] cv, logic [7:0] nu,
                                              logic [7:0] nv);
    bfgt_pkg::vec3_t pts [6];
    bfgt_pkg::vec3_t a, b, c, d;
    logic            flip;
    vertex_t         vx;
    flip = (face == bfgt_pkg::FACE_POS_X || face == bfgt_pkg::FACE_NEG_Y ||
            face == bfgt_pkg::FACE_POS_Z) ^ ccw_front;
    a = face_corner(face, 32'(cu),         32'(cv),         nu, nv);
    b = face_corner(face, 32'(cu),         32'(cv) + 32'd1, nu, nv);
    c = face_corner(face, 32'(cu) + 32'd1, 32'(cv),         nu, nv);
    d = face_corner(face, 32'(cu) + 32'd1, 32'(cv) + 32'd1, nu, nv);
    pts[bfgt_pkg::SLOT_FIRST]    = a;
    pts[bfgt_pkg::SLOT_NEAR]     = flip ? c : b;
    pts[bfgt_pkg::SLOT_FAR]      = flip ? b : c;
    pts[bfgt_pkg::SLOT_FAR_DUP]  = pts[bfgt_pkg::SLOT_FAR];
    pts[bfgt_pkg::SLOT_NEAR_DUP] = pts[bfgt_pkg::SLOT_NEAR];
    pts[bfgt_pkg::SLOT_LAST]     = d;
    for (int k = 0; k < 6; k++) begin
      vx.x    = pts[k][0];
      vx.y    = pts[k][1];
      vx.z    = pts[k][2];
      vx.slot = 3'(k);
      vx.last = (k == bfgt_pkg::SLOT_LAST);
      vertices_due.push_back(vx);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      n_errors++;
      $error("%s: expected %h, got %h", name, want, got);
    end
  endfunction

  // Driver: a request on the ports is known taken once n_taken catches up with
  // n_issued. The next one follows after its own random gap; start is given a
  // single assignment per falling edge so a back-to-back request never drops it.
  always @(negedge clk_i) begin : feed
    logic      go;
    cell_req_t nxt;
    go = start;
    if (rst_ni) begin
      if (start && n_taken == n_issued) go = 1'b0;
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cells.size() > 0 &&
                     !(pending_cells[0].drain_first && vertices_due.size() != 0)) begin
          nxt = pending_cells.pop_front();
          face_i    <= nxt.face;
          cell_u_i  <= nxt.cu;
          cell_v_i  <= nxt.cv;
          count_u_i <= nxt.nu;
          count_v_i <= nxt.nv;
          go        = 1'b1;
          n_issued++;
          gap_left  = $urandom_range(0, gap_cap);
        end
      end
    end
    start <= go;
  end

  // Monitor: register writes update the shadow, accepted requests are predicted
  // and every vertex strobe is checked against the oldest prediction.
  always @(posedge clk_i) begin : observe
    vertex_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          bfgt_pkg::REG_MIN_X: box_lo[0] = cfg_data_i;
          bfgt_pkg::REG_MIN_Y: box_lo[1] = cfg_data_i;
          bfgt_pkg::REG_MIN_Z: box_lo[2] = cfg_data_i;
          bfgt_pkg::REG_MAX_X: box_hi[0] = cfg_data_i;
          bfgt_pkg::REG_MAX_Y: box_hi[1] = cfg_data_i;
          bfgt_pkg::REG_MAX_Z: box_hi[2] = cfg_data_i;
          bfgt_pkg::REG_CCW:   ccw_front = cfg_data_i[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        queue_cell_vertices(face_i, cell_u_i, cell_v_i, count_u_i, count_v_i);
        n_taken++;
      end
      if (vertex_valid_o) begin
        if (vertices_due.size() == 0) begin
          n_errors++;
          $error("vertex slot %0d arrived with no request outstanding", corner_slot_o);
        end else begin
          want = vertices_due.pop_front();
          check_field("vertex_x", want.x, vertex_x_o);
          check_field("vertex_y", want.y, vertex_y_o);
          check_field("vertex_z", want.z, vertex_z_o);
          check_field("corner_slot", 32'(want.slot), 32'(corner_slot_o));
          check_field("last_vertex", 32'(want.last), 32'(last_vertex_o));
          n_checked++;
        end
      end
    end
  end

  // Watchdog on traffic of any kind; a stuck handshake ends the run.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start && !busy) || vertex_valid_o || (cfg_valid_i && cfg_ready_o))
      idle_cycs <= 0;
    else
      idle_cycs <= idle_cycs + 1;
    if (idle_cycs >= IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles, %0d vertices still due",
               idle_cycs, vertices_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(bfgt_pkg::reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_box(logic [31:0] mnx, logic [31:0] mny, logic [31:0] mnz,
                          logic [31:0] mxx, logic [31:0] mxy, logic [31:0] mxz,
                          logic ccw);
    write_reg(bfgt_pkg::REG_MIN_X, mnx);
    write_reg(bfgt_pkg::REG_MIN_Y, mny);
    write_reg(bfgt_pkg::REG_MIN_Z, mnz);
    write_reg(bfgt_pkg::REG_MAX_X, mxx);
    write_reg(bfgt_pkg::REG_MAX_Y, mxy);
    write_reg(bfgt_pkg::REG_MAX_Z, mxz);
    write_reg(bfgt_pkg::REG_CCW, {31'd0, ccw});
    n_settings++;
  endtask

  task automatic queue_req(logic [2:0] face, logic [7:0] cu, logic [7:0] cv,
                           logic [7:0] nu, logic [7:0] nv, bit drain);
    cell_req_t r;
    r.face = face;
    r.cu = cu;
    r.cv = cv;
    r.nu = nu;
    r.nv = nv;
    r.drain_first = drain;
    pending_cells.push_back(r);
  endtask

  // Mostly well-formed cells inside the grid, small grids often; a tenth are
  // off-grid cells or zero counts, and the odd request uses an unused face code.
  task automatic queue_random_reqs(int unsigned n);
    int unsigned pick;
    logic [2:0]  face;
    logic [7:0]  cu, cv, nu, nv;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      face = (pick < 5) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      if (pick >= 90) begin
        cu = 8'($urandom);
        cv = 8'($urandom);
        nu = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
        nv = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
      end else begin
        nu = (pick < 40) ? 8'($urandom_range(1, 8)) : 8'($urandom_range(1, 255));
        nv = (pick < 40) ? 8'($urandom_range(1, 8)) : 8'($urandom_range(1, 255));
        cu = 8'($urandom_range(0, 32'(nu) - 32'd1));
        cv = 8'($urandom_range(0, 32'(nv) - 32'd1));
      end
      queue_req(face, cu, cv, nu, nv, $urandom_range(0, 39) == 0);
    end
  endtask

  // Wait for every queued request to be taken and its vertices checked, then
  // give the pipeline time to show any stray output before the next write.
  task automatic settle();
    do @(negedge clk_i);
    while (pending_cells.size() != 0 || n_taken != n_issued || vertices_due.size() != 0);
    repeat (SETTLE_CYCS) @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [31:0] lo [3];
    logic [31:0] span [3];
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset box (all zero) first
    queue_req(bfgt_pkg::FACE_NEG_X, 8'd0, 8'd0, 8'd1, 8'd1, 1'b0);
    queue_req(bfgt_pkg::FACE_POS_Z, 8'd3, 8'd7, 8'd4, 8'd8, 1'b0);
    settle();

    // Widest box: full Q16.16 range on every axis
    load_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    for (int f = 0; f < 8; f++) queue_req(3'(f), 8'd0, 8'd0, 8'd1, 8'd1, 1'b0);
    queue_req(bfgt_pkg::FACE_NEG_X, 8'd254, 8'd254, 8'd255, 8'd255, 1'b0);
    // top cell of a full grid, past the box and wrapping
    queue_req(bfgt_pkg::FACE_POS_Y, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    queue_req(bfgt_pkg::FACE_NEG_Z, 8'd255, 8'd0, 8'd255, 8'd1, 1'b0);
    // zero counts pin the axis to the low corner
    queue_req(bfgt_pkg::FACE_NEG_Y, 8'd5, 8'd9, 8'd0, 8'd12, 1'b0);
    queue_req(bfgt_pkg::FACE_POS_X, 8'd9, 8'd5, 8'd12, 8'd0, 1'b0);
    queue_req(bfgt_pkg::FACE_POS_Z, 8'd200, 8'd17, 8'd3, 8'd2, 1'b0);
    queue_req(bfgt_pkg::FACE_NEG_Z, 8'hAA, 8'h55, 8'hFF, 8'hAA, 1'b0);
    queue_req(bfgt_pkg::FACE_POS_Y, 8'h55, 8'hAA, 8'h55, 8'hFF, 1'b1);
    settle();

    // Inverted extents, winding inverted
    for (int a = 0; a < 3; a++) begin
      lo[a] = $urandom; lo[a][31] = 1'b0;
      span[a] = $urandom; span[a][31] = 1'b1;
    end
    load_box(lo[0], lo[1], lo[2], span[0], span[1], span[2], 1'b1);
    queue_random_reqs(50);
    settle();

    // Any bit pattern at all
    for (int a = 0; a < 3; a++) begin
      lo[a] = $urandom;
      span[a] = $urandom;
    end
    load_box(lo[0], lo[1], lo[2], span[0], span[1], span[2], 1'($urandom));
    queue_random_reqs(60);
    settle();

    // Small box around the origin, requests back to back
    for (int a = 0; a < 3; a++) begin
      lo[a] = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      span[a] = lo[a] + $urandom_range(0, 32'h00FF_FFFF);
    end
    load_box(lo[0], lo[1], lo[2], span[0], span[1], span[2], 1'b0);
    gap_cap = 0;
    queue_random_reqs(60);
    settle();
    gap_cap = 10;

    // Flat box: min equals max on every axis
    for (int a = 0; a < 3; a++) lo[a] = $urandom;
    load_box(lo[0], lo[1], lo[2], lo[0], lo[1], lo[2], 1'b1);
    queue_random_reqs(40);
    settle();

    // Ordinary ordered box
    for (int a = 0; a < 3; a++) begin
      lo[a] = $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
      span[a] = lo[a] + $urandom_range(0, 32'h3FFF_FFFF);
    end
    load_box(lo[0], lo[1], lo[2], span[0], span[1], span[2], 1'b0);
    queue_random_reqs(60);
    settle();

    // Corners swapped at the extremes: largest negative extent
    load_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    queue_random_reqs(60);
    settle();

    $display("Checked %0d vertices from %0d cell requests over %0d box settings",
             n_checked, n_taken, n_settings);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/bfgt_pkg.sv
src/bfgt_cfg_regs.sv
src/bfgt_front.sv
src/bfgt_div_stage.sv
src/bfgt_emit.sv
src/box_face_grid_tessellator.sv
src/bfgt_checker.sv
bench/tb_box_face_grid_tessellator.sv
